@@ sv/go_to_goal_controller_defines.svh @@
// Assertion macros shared by the go-to-goal controller checkers
// Depends on nothing; included by files that hold concurrent assertions
`ifndef GO_TO_GOAL_CONTROLLER_DEFINES_SVH
`define GO_TO_GOAL_CONTROLLER_DEFINES_SVH

// same-cycle implication, reset-gated
`define GTG_ASSERT_IMPL(name, clk_s, rst_s, ante, cons) \
    name: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error("go_to_goal_controller: assertion failed");

// next-cycle implication, reset-gated
`define GTG_ASSERT_NEXT(name, clk_s, rst_s, ante, cons) \
    name: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error("go_to_goal_controller: assertion failed");

`endif

@@ sv/gtg_pkg.sv @@
// Shared types, constants and tables of the go-to-goal controller
// Depends on nothing; imported by every module of the block
package gtg_pkg;

    // configuration port
    localparam int CFG_W     = 15;
    localparam int CFG_IDX_W = 3;

    // loop sequencing
    localparam int STEP_W           = 5;
    localparam int SQRT_STEPS       = 18;
    localparam int CORDIC_STEPS_DEF = 16;

    // fixed-point constants
    localparam logic signed [33:0] HALF_PI_Q30    = 34'sd1686629713;
    localparam logic [33:0]        ROUND_Q30_Q12  = 34'd131072;
    localparam logic [15:0]        PI_Q12         = 16'd12868;
    localparam logic [16:0]        FLIP_LIMIT_Q12 = 17'd12861;
    localparam logic [34:0]        SQRT_TOP_BIT   = 35'h4_0000_0000;

    // register reset values
    localparam logic [11:0] HEADING_GAIN_RST     = 12'd128;
    localparam logic [11:0] DISTANCE_GAIN_RST    = 12'd128;
    localparam logic [14:0] MAX_LINEAR_RST       = 15'd6144;
    localparam logic [14:0] MAX_ANGULAR_RST      = 15'd12868;
    localparam logic [14:0] ALIGN_THRESHOLD_RST  = 15'd410;
    localparam logic [14:0] ARRIVE_THRESHOLD_RST = 15'd13;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_HEADING_GAIN     = 3'd0,
        REG_DISTANCE_GAIN    = 3'd1,
        REG_MAX_LINEAR       = 3'd2,
        REG_MAX_ANGULAR      = 3'd3,
        REG_ALIGN_THRESHOLD  = 3'd4,
        REG_ARRIVE_THRESHOLD = 3'd5
    } gtg_reg_idx_t;

    typedef enum logic [1:0] {
        ST_RUNNING   = 2'd0,
        ST_ARRIVED   = 2'd1,
        ST_PREEMPTED = 2'd2,
        ST_IDLE      = 2'd3
    } gtg_status_t;

    // input word
    typedef struct packed {
        logic               start_goal;
        logic               preempt;
        logic signed [15:0] goal_x;
        logic signed [15:0] goal_y;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] heading;
    } gtg_in_t;

    // result word
    typedef struct packed {
        logic signed [15:0] linear_cmd;
        logic signed [15:0] angular_cmd;
        logic [1:0]         status;
    } gtg_out_t;

    // controller to datapath
    typedef struct packed {
        logic              load;
        logic              sq_x;
        logic              sq_y;
        logic              sum;
        logic              cordic_step;
        logic              sqrt_step;
        logic [STEP_W-1:0] step;
        logic              bearing;
        logic              error;
        logic              mul_ang;
        logic              mul_lin;
        logic              write_out;
    } gtg_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic run;
    } gtg_stat_t;

    // arctan(2^-i) in Q30
    function automatic logic [29:0] atan_q30(input logic [STEP_W-1:0] idx);
        logic [29:0] val;
        case (idx)
            5'd0:    val = 30'd843314857;
            5'd1:    val = 30'd497837829;
            5'd2:    val = 30'd263043837;
            5'd3:    val = 30'd133525159;
            5'd4:    val = 30'd67021687;
            5'd5:    val = 30'd33543516;
            5'd6:    val = 30'd16775851;
            5'd7:    val = 30'd8388437;
            5'd8:    val = 30'd4194283;
            5'd9:    val = 30'd2097149;
            5'd10:   val = 30'd1048576;
            5'd11:   val = 30'd524288;
            5'd12:   val = 30'd262144;
            5'd13:   val = 30'd131072;
            5'd14:   val = 30'd65536;
            5'd15:   val = 30'd32768;
            5'd16:   val = 30'd16384;
            5'd17:   val = 30'd8192;
            5'd18:   val = 30'd4096;
            5'd19:   val = 30'd2048;
            5'd20:   val = 30'd1024;
            5'd21:   val = 30'd512;
            5'd22:   val = 30'd256;
            5'd23:   val = 30'd128;
            default: val = 30'd0;
        endcase
        return val;
    endfunction

endpackage

@@ sv/gtg_stream_if.sv @@
// Valid/ready stream channel carrying one word of type T
// Depends on nothing; the payload type comes from the instantiating level
interface gtg_stream_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ sv/go_to_goal_controller.sv @@
// Go-to-goal proportional controller. A word taken on in_ch yields exactly one
// word on out_ch. For a running goal the next word can be taken once the
// iteration loop that runs the bearing CORDIC and the distance square root
// side by side, one step each per cycle, and the shared multiplier passes are
// through. Preempted words and words with no active goal go straight to the
// result. The result sits in an output register, so a new word is taken while
// the previous result still waits on out_ch; that new word then holds in its
// last state until out_ch takes the waiting result.
// The user is to write configuration through cfg_we/cfg_index/cfg_data only
// while the block is idle; the block itself does not enforce this.
// Depends on gtg_pkg, gtg_stream_if, gtg_ctrl and gtg_datapath
module go_to_goal_controller
    import gtg_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    gtg_stream_if.sink           in_ch,
    gtg_stream_if.source         out_ch,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    gtg_cmd_t  cmd;
    gtg_stat_t stat;
    gtg_in_t   in_word;
    gtg_out_t  out_word;
    logic      in_ready;
    logic      out_valid;

    assign in_word = in_ch.data;

    // sequencer
    gtg_ctrl #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ch.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // arithmetic and state
    gtg_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .in_word   (in_word),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .stat      (stat),
        .out_word  (out_word)
    );

    assign in_ch.ready  = in_ready;
    assign out_ch.valid = out_valid;
    assign out_ch.data  = out_word;

endmodule

@@ sv/gtg_ctrl.sv @@
// Sequencer of the go-to-goal controller: one-hot state machine and loop counter
// Depends on gtg_pkg; drives the datapath through gtg_cmd_t
module gtg_ctrl
    import gtg_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    input  gtg_stat_t stat,
    output gtg_cmd_t  cmd
);

    localparam int LOOP_N = (CORDIC_STEPS > SQRT_STEPS) ? CORDIC_STEPS : SQRT_STEPS;
    localparam logic [STEP_W-1:0] LAST_STEP  = STEP_W'(LOOP_N - 1);
    localparam logic [STEP_W-1:0] CORDIC_END = STEP_W'(CORDIC_STEPS);
    localparam logic [STEP_W-1:0] SQRT_END   = STEP_W'(SQRT_STEPS);

    typedef enum logic [9:0] {
        S_IDLE = 10'b00_0000_0001,
        S_SQX  = 10'b00_0000_0010,
        S_SQY  = 10'b00_0000_0100,
        S_SUM  = 10'b00_0000_1000,
        S_ITER = 10'b00_0001_0000,
        S_BRG  = 10'b00_0010_0000,
        S_ERR  = 10'b00_0100_0000,
        S_MANG = 10'b00_1000_0000,
        S_MLIN = 10'b01_0000_0000,
        S_DONE = 10'b10_0000_0000
    } state_t;

    state_t            state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              out_valid_reg, out_valid_next;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        cmd.step   = step_reg;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_SQX;
                end
            end
            S_SQX:
            begin
                // preempt or no goal: straight to the result
                if (!stat.run)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.sq_x   = 1'b1;
                    state_next = S_SQY;
                end
            end
            S_SQY:
            begin
                cmd.sq_y   = 1'b1;
                state_next = S_SUM;
            end
            S_SUM:
            begin
                cmd.sum    = 1'b1;
                step_next  = '0;
                state_next = S_ITER;
            end
            S_ITER:
            begin
                cmd.cordic_step = (step_reg < CORDIC_END);
                cmd.sqrt_step   = (step_reg < SQRT_END);
                if (step_reg == LAST_STEP)
                begin
                    state_next = S_BRG;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            S_BRG:
            begin
                cmd.bearing = 1'b1;
                state_next  = S_ERR;
            end
            S_ERR:
            begin
                cmd.error  = 1'b1;
                state_next = S_MANG;
            end
            S_MANG:
            begin
                cmd.mul_ang = 1'b1;
                state_next  = S_MLIN;
            end
            S_MLIN:
            begin
                cmd.mul_lin = 1'b1;
                state_next  = S_DONE;
            end
            S_DONE:
            begin
                // wait until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.write_out = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // output word valid flag
    always_comb
    begin
        if (cmd.write_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

@@ sv/gtg_datapath.sv @@
// Datapath of the go-to-goal controller: config registers, shared multiplier,
// vectoring CORDIC, bitwise square root, drive shaping and the output register
// Depends on gtg_pkg; commanded by gtg_ctrl
module gtg_datapath
    import gtg_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  gtg_cmd_t             cmd,
    input  gtg_in_t              in_word,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    output gtg_stat_t            stat,
    output gtg_out_t             out_word
);

    // configuration
    logic [11:0] heading_gain_reg;
    logic [11:0] distance_gain_reg;
    logic [14:0] max_linear_reg;
    logic [14:0] max_angular_reg;
    logic [14:0] align_threshold_reg;
    logic [14:0] arrive_threshold_reg;

    // goal state
    logic        goal_active_reg, goal_active_next;
    logic        aligned_reg, aligned_next;
    logic        run_reg, run_next;
    gtg_status_t status_reg, status_next;

    // payload
    logic signed [16:0] dx_reg, dy_reg;
    logic signed [15:0] heading_reg;
    logic [35:0]        prod_reg, prod_next;
    logic [33:0]        acc_reg;
    logic [34:0]        sq_n_reg, sq_r_reg, sq_bit_reg;
    logic               zero_reg;
    logic signed [27:0] x_reg, y_reg;
    logic signed [33:0] z_reg;
    logic signed [15:0] brg_reg;
    logic [17:0]        dist_reg;
    logic signed [16:0] err_reg;
    logic [16:0]        aerr_reg;
    logic [14:0]        angm_reg;
    gtg_out_t           out_reg;

    // combinational helpers
    logic [16:0]        adx, ady;
    logic [17:0]        mul_a, mul_b;
    logic signed [27:0] xs, ys, x_init, y_init;
    logic signed [33:0] z_init;
    logic signed [27:0] xsh, ysh;
    logic [33:0]        atan_z;
    logic [35:0]        trial;
    logic [33:0]        zmag, zrnd;
    logic [15:0]        zq, zcl;
    logic signed [15:0] brg_val;
    logic [17:0]        dist_val;
    logic signed [16:0] err_val;
    logic [29:0]        ang_sum;
    logic [21:0]        ang_q;
    logic [14:0]        angm_val;
    logic [30:0]        lin_sum;
    logic [26:0]        lin_q;
    logic [14:0]        linm;
    logic               aligned_now, arrive, flip, err_pos, err_neg, ang_pos;
    logic signed [15:0] angm16, ang_val, lin_val;
    gtg_out_t           out_val;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heading_gain_reg     <= HEADING_GAIN_RST;
            distance_gain_reg    <= DISTANCE_GAIN_RST;
            max_linear_reg       <= MAX_LINEAR_RST;
            max_angular_reg      <= MAX_ANGULAR_RST;
            align_threshold_reg  <= ALIGN_THRESHOLD_RST;
            arrive_threshold_reg <= ARRIVE_THRESHOLD_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_HEADING_GAIN:     heading_gain_reg     <= cfg_data[11:0];
                REG_DISTANCE_GAIN:    distance_gain_reg    <= cfg_data[11:0];
                REG_MAX_LINEAR:       max_linear_reg       <= cfg_data;
                REG_MAX_ANGULAR:      max_angular_reg      <= cfg_data;
                REG_ALIGN_THRESHOLD:  align_threshold_reg  <= cfg_data;
                REG_ARRIVE_THRESHOLD: arrive_threshold_reg <= cfg_data;
                default:              ;
            endcase
        end
    end

    // absolute coordinate differences
    assign adx = dx_reg[16] ? 17'(-dx_reg) : 17'(dx_reg);
    assign ady = dy_reg[16] ? 17'(-dy_reg) : 17'(dy_reg);

    // shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        if (cmd.sq_x)
        begin
            mul_a = 18'(adx);
            mul_b = 18'(adx);
        end
        else if (cmd.sq_y)
        begin
            mul_a = 18'(ady);
            mul_b = 18'(ady);
        end
        else if (cmd.mul_ang)
        begin
            mul_a = 18'(aerr_reg);
            mul_b = 18'(heading_gain_reg);
        end
        else if (cmd.mul_lin)
        begin
            mul_a = dist_reg;
            mul_b = 18'(distance_gain_reg);
        end
        prod_next = mul_a * mul_b;
    end

    // cordic pre-rotation into the right half plane
    always_comb
    begin
        xs = $signed({{3{dx_reg[16]}}, dx_reg, 8'd0});
        ys = $signed({{3{dy_reg[16]}}, dy_reg, 8'd0});
        x_init = xs;
        y_init = ys;
        z_init = '0;
        if (xs < 0)
        begin
            if (ys >= 0)
            begin
                x_init = ys;
                y_init = -xs;
                z_init = HALF_PI_Q30;
            end
            else
            begin
                x_init = -ys;
                y_init = xs;
                z_init = -HALF_PI_Q30;
            end
        end
    end

    // one cordic micro-rotation and one square root trial
    assign xsh    = x_reg >>> cmd.step;
    assign ysh    = y_reg >>> cmd.step;
    assign atan_z = {4'd0, atan_q30(cmd.step)};
    assign trial  = {1'b0, sq_r_reg} + {1'b0, sq_bit_reg};

    // bearing rounding and clamp, square root rounding
    always_comb
    begin
        zmag = z_reg[33] ? 34'(-z_reg) : 34'(z_reg);
        zrnd = zmag + ROUND_Q30_Q12;
        zq   = zrnd[33:18];
        zcl  = (zq > PI_Q12) ? PI_Q12 : zq;
        if (zero_reg)
        begin
            brg_val = '0;
        end
        else if (z_reg[33])
        begin
            brg_val = -$signed(zcl);
        end
        else
        begin
            brg_val = $signed(zcl);
        end
        dist_val = (sq_n_reg > sq_r_reg) ? (sq_r_reg[17:0] + 18'd1) : sq_r_reg[17:0];
    end

    assign err_val = $signed({brg_reg[15], brg_reg}) - $signed({heading_reg[15], heading_reg});

    // angular magnitude, clamped
    assign ang_sum  = {1'b0, prod_reg[28:0]} + 30'd128;
    assign ang_q    = ang_sum[29:8];
    assign angm_val = (ang_q > {7'd0, max_angular_reg}) ? max_angular_reg : ang_q[14:0];

    // linear magnitude, clamped
    assign lin_sum = {1'b0, prod_reg[29:0]} + 31'd8;
    assign lin_q   = lin_sum[30:4];
    assign linm    = (lin_q > {12'd0, max_linear_reg}) ? max_linear_reg : lin_q[14:0];

    // drive shaping and arrival
    always_comb
    begin
        aligned_now = aligned_reg | (aerr_reg < {2'd0, align_threshold_reg});
        arrive      = dist_reg < {3'd0, arrive_threshold_reg};
        flip        = aerr_reg > FLIP_LIMIT_Q12;
        err_neg     = err_reg[16];
        err_pos     = !err_reg[16] && (err_reg != 17'sd0);
        ang_pos     = flip ? err_pos : err_neg;
        angm16      = $signed({1'b0, angm_reg});
        ang_val     = ang_pos ? angm16 : -angm16;
        lin_val     = aligned_now ? $signed({1'b0, linm}) : 16'sd0;

        out_val = '0;
        if (!run_reg)
        begin
            out_val.status = status_reg;
        end
        else if (arrive)
        begin
            out_val.status = ST_ARRIVED;
        end
        else
        begin
            out_val.linear_cmd  = lin_val;
            out_val.angular_cmd = ang_val;
            out_val.status      = ST_RUNNING;
        end
    end

    // goal and alignment state
    always_comb
    begin
        goal_active_next = goal_active_reg;
        aligned_next     = aligned_reg;
        run_next         = run_reg;
        status_next      = status_reg;
        if (cmd.load)
        begin
            if (in_word.preempt)
            begin
                goal_active_next = 1'b0;
                aligned_next     = 1'b0;
                run_next         = 1'b0;
                status_next      = ST_PREEMPTED;
            end
            else
            begin
                if (in_word.start_goal)
                begin
                    goal_active_next = 1'b1;
                    aligned_next     = 1'b0;
                end
                run_next    = in_word.start_goal | goal_active_reg;
                status_next = ST_IDLE;
            end
        end
        else if (cmd.write_out && run_reg)
        begin
            if (arrive)
            begin
                goal_active_next = 1'b0;
                aligned_next     = 1'b0;
            end
            else
            begin
                aligned_next = aligned_now;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            goal_active_reg <= 1'b0;
            aligned_reg     <= 1'b0;
            run_reg         <= 1'b0;
        end
        else
        begin
            goal_active_reg <= goal_active_next;
            aligned_reg     <= aligned_next;
            run_reg         <= run_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        if (cmd.load)
        begin
            dx_reg      <= $signed({in_word.goal_x[15], in_word.goal_x})
                           - $signed({in_word.pos_x[15], in_word.pos_x});
            dy_reg      <= $signed({in_word.goal_y[15], in_word.goal_y})
                           - $signed({in_word.pos_y[15], in_word.pos_y});
            heading_reg <= in_word.heading;
        end
        if (cmd.sq_x || cmd.sq_y || cmd.mul_ang || cmd.mul_lin)
        begin
            prod_reg <= prod_next;
        end
        if (cmd.sq_y)
        begin
            acc_reg <= prod_reg[33:0];
        end
        if (cmd.sum)
        begin
            sq_n_reg   <= {1'b0, acc_reg} + {1'b0, prod_reg[33:0]};
            sq_r_reg   <= '0;
            sq_bit_reg <= SQRT_TOP_BIT;
            zero_reg   <= (dx_reg == 17'sd0) && (dy_reg == 17'sd0);
            x_reg      <= x_init;
            y_reg      <= y_init;
            z_reg      <= z_init;
        end
        if (cmd.cordic_step)
        begin
            if (!y_reg[27])
            begin
                x_reg <= x_reg + ysh;
                y_reg <= y_reg - xsh;
                z_reg <= z_reg + $signed(atan_z);
            end
            else
            begin
                x_reg <= x_reg - ysh;
                y_reg <= y_reg + xsh;
                z_reg <= z_reg - $signed(atan_z);
            end
        end
        if (cmd.sqrt_step)
        begin
            if ({1'b0, sq_n_reg} >= trial)
            begin
                sq_n_reg <= sq_n_reg - trial[34:0];
                sq_r_reg <= (sq_r_reg >> 1) + sq_bit_reg;
            end
            else
            begin
                sq_r_reg <= sq_r_reg >> 1;
            end
            sq_bit_reg <= sq_bit_reg >> 2;
        end
        if (cmd.bearing)
        begin
            brg_reg  <= brg_val;
            dist_reg <= dist_val;
        end
        if (cmd.error)
        begin
            err_reg  <= err_val;
            aerr_reg <= err_val[16] ? 17'(-err_val) : 17'(err_val);
        end
        if (cmd.mul_lin)
        begin
            angm_reg <= angm_val;
        end
        if (cmd.write_out)
        begin
            out_reg <= out_val;
        end
    end

    assign stat.run = run_reg;
    assign out_word = out_reg;

endmodule

@@ sv/gtg_checker.sv @@
// Port-level checks of the go-to-goal controller, bound to the top level
// Depends on gtg_pkg and go_to_goal_controller_defines.svh
`include "go_to_goal_controller_defines.svh"

module gtg_checker
    import gtg_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     in_valid,
    input logic     in_ready,
    input logic     out_valid,
    input logic     out_ready,
    input gtg_out_t out_data
);

    // a stalled result word holds
    `GTG_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data))

    // block is busy right after taking a word
    `GTG_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)

    // any status but running carries zero drives
    `GTG_ASSERT_IMPL(a_stopped_zero, clk, rst_n, out_valid && (out_data.status != ST_RUNNING), (out_data.linear_cmd == 16'sd0) && (out_data.angular_cmd == 16'sd0))

    // linear drive never reverses
    `GTG_ASSERT_IMPL(a_linear_forward, clk, rst_n, out_valid, !out_data.linear_cmd[15])

endmodule

bind go_to_goal_controller gtg_checker u_gtg_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (out_ch.data)
);
